FILE: rtl/dtrb_pkg.sv
// ----------------------------------------------------------------------------
// dtrb_pkg
// Shared types and constants of the transmit ring buffer.
// ----------------------------------------------------------------------------
package dtrb_pkg;

    localparam int BUFFER_BYTES = 8192;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = PTR_W + 1;

    localparam int IDX_W        = 13;
    localparam int LEN_W        = 14;

    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 56;

    localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_DONE = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RUN_STOPPED = 3'b001,
        RUN_IDLE    = 3'b010,
        RUN_BUSY    = 3'b100
    } run_state_t;

    typedef enum logic [2:0] {
        CTRL_WAIT = 3'b001,
        CTRL_EXEC = 3'b010,
        CTRL_SEND = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dtrb_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] free_space;
        logic [7:0]       read_data;
        logic [LEN_W-1:0] launch_length;
        logic [IDX_W-1:0] launch_start;
        logic             launch_valid;
        logic             accepted;
    } dtrb_result_t;

endpackage

FILE: rtl/dtrb_ctrl.sv
// ----------------------------------------------------------------------------
// dtrb_ctrl
// Handshake sequencer: takes one beat, runs it through the datapath, holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module dtrb_ctrl
    import dtrb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output dtrb_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_WAIT: begin
                if (s_tvalid) state_next = CTRL_EXEC;
            end
            CTRL_EXEC: begin
                state_next = CTRL_SEND;
            end
            CTRL_SEND: begin
                if (m_tready) state_next = CTRL_WAIT;
            end
            default: begin
                state_next = CTRL_WAIT;
            end
        endcase
    end

    assign s_tready    = (state_reg == CTRL_WAIT);
    assign m_tvalid    = (state_reg == CTRL_SEND);
    assign cmd.capture = s_tvalid && (state_reg == CTRL_WAIT);
    assign cmd.execute = (state_reg == CTRL_EXEC);

endmodule

FILE: rtl/dtrb_datapath.sv
// ----------------------------------------------------------------------------
// dtrb_datapath
// Byte store, ring pointers, free space count and transfer launch logic.
// ----------------------------------------------------------------------------
module dtrb_datapath
    import dtrb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dtrb_cmd_t        cmd,
    input  logic [1:0]       in_mode,
    input  logic [7:0]       in_data_byte,
    input  logic             in_end_of_message,
    input  logic [IDX_W-1:0] in_read_index,
    input  logic             cfg_wen,
    input  logic             cfg_wdata,
    output dtrb_result_t     result
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] mem_rd_reg;

    logic [1:0]       mode_reg;
    logic [7:0]       data_reg;
    logic             eom_reg;
    logic [IDX_W-1:0] ridx_reg;

    logic [PTR_W-1:0] write_pos_reg, write_pos_next;
    logic [PTR_W-1:0] send_pos_reg, send_pos_next;
    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic [CNT_W-1:0] space_reg, space_next;
    run_state_t       run_reg, run_next;
    dtrb_result_t     result_reg, result_next;

    logic             mem_wen;
    logic             do_launch;
    logic [PTR_W-1:0] wp_mid;
    logic [PTR_W-1:0] sp_mid;
    logic [CNT_W-1:0] space_mid;
    logic [CNT_W-1:0] ie_mid;
    logic [CNT_W-1:0] sent;
    logic [CNT_W:0]   space_sum;
    logic [CNT_W-1:0] stop;
    logic [CNT_W-1:0] launch_len;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mem_rd_reg <= mem[in_read_index[PTR_W-1:0]];
            mode_reg   <= in_mode;
            data_reg   <= in_data_byte;
            eom_reg    <= in_end_of_message;
            ridx_reg   <= in_read_index;
        end
        if (mem_wen) begin
            mem[write_pos_reg] <= data_reg;
        end
    end

    // launch unit: run from send pointer to write pointer or to the buffer end
    always_comb begin
        if (({1'b0, wp_mid} < {1'b0, sp_mid}) || (wp_mid == sp_mid && space_mid == '0)) begin
            stop = BUF_CNT;
        end else begin
            stop = {1'b0, wp_mid};
        end
        launch_len = stop - {1'b0, sp_mid};
    end

    always_comb begin
        mem_wen        = 1'b0;
        do_launch      = 1'b0;
        wp_mid         = write_pos_reg;
        sp_mid         = send_pos_reg;
        space_mid      = space_reg;
        ie_mid         = inflight_reg;
        sent           = '0;
        space_sum      = '0;
        write_pos_next = write_pos_reg;
        send_pos_next  = send_pos_reg;
        inflight_next  = inflight_reg;
        space_next     = space_reg;
        run_next       = run_reg;
        result_next    = result_reg;

        if (cmd.execute) begin
            result_next = '0;
            case (mode_t'(mode_reg))
                MODE_PUSH: begin
                    if (space_reg != '0) begin
                        mem_wen = 1'b1;
                        if ({1'b0, write_pos_reg} == BUF_CNT - 1'b1) begin
                            wp_mid = '0;
                        end else begin
                            wp_mid = write_pos_reg + 1'b1;
                        end
                        space_mid            = space_reg - 1'b1;
                        result_next.accepted = 1'b1;
                    end
                    do_launch = eom_reg && (run_reg == RUN_IDLE);
                end
                MODE_DONE: begin
                    if (run_reg == RUN_BUSY) begin
                        if (inflight_reg >= {1'b0, send_pos_reg}) begin
                            sent = inflight_reg - {1'b0, send_pos_reg};
                        end
                        space_sum = {1'b0, space_reg} + {1'b0, sent};
                        if (space_sum > {1'b0, BUF_CNT}) begin
                            space_mid = BUF_CNT;
                        end else begin
                            space_mid = space_sum[CNT_W-1:0];
                        end
                        if (inflight_reg >= BUF_CNT) begin
                            ie_mid = '0;
                        end else begin
                            ie_mid = inflight_reg;
                        end
                        sp_mid = ie_mid[PTR_W-1:0];
                        if (write_pos_reg == sp_mid && space_mid != '0) begin
                            run_next = RUN_IDLE;
                        end else begin
                            do_launch = 1'b1;
                        end
                    end
                end
                MODE_READ: begin
                    if ({1'b0, ridx_reg} < LEN_W'(BUFFER_BYTES)) begin
                        result_next.read_data = mem_rd_reg;
                    end
                end
                default: begin
                end
            endcase

            write_pos_next = wp_mid;
            send_pos_next  = sp_mid;
            space_next     = space_mid;
            inflight_next  = ie_mid;
            if (do_launch) begin
                inflight_next              = stop;
                run_next                   = RUN_BUSY;
                result_next.launch_valid   = 1'b1;
                result_next.launch_start   = IDX_W'(sp_mid);
                result_next.launch_length  = LEN_W'(launch_len);
            end
            result_next.free_space = LEN_W'(space_mid);
        end

        if (cfg_wen) begin
            if (cfg_wdata) begin
                if (run_reg == RUN_STOPPED) run_next = RUN_IDLE;
            end else begin
                run_next       = RUN_STOPPED;
                write_pos_next = '0;
                send_pos_next  = '0;
                inflight_next  = '0;
                space_next     = BUF_CNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg <= '0;
            send_pos_reg  <= '0;
            inflight_reg  <= '0;
            space_reg     <= BUF_CNT;
            run_reg       <= RUN_STOPPED;
        end else begin
            write_pos_reg <= write_pos_next;
            send_pos_reg  <= send_pos_next;
            inflight_reg  <= inflight_next;
            space_reg     <= space_next;
            run_reg       <= run_next;
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: rtl/dma_tx_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// dma_tx_ring_buffer_unit
// Byte ring buffer feeding a serial DMA engine, with transfer chunking.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one command beat; tuser = mode (push, done, read, nop),
//   tlast = end of message, tdata = data byte and read index.
//   m_ channel: one result beat per command beat, in order.
//   cfg_wen/cfg_wdata write link_enable; 0 stops launches and clears the
//   pointers, 1 attaches the link. Write only while no beat is in flight.
//   The controller takes one beat at a time: it is captured in the
//   wait state, run in the exec state, and its registered result is
//   offered in the send state. The byte store read is registered.
//   While the receiver stalls the result is held and s_tready stays low.
//   Reset (aresetn low, synchronous) clears the pointers, sets free space
//   to the full buffer and stops the link; the byte store is not cleared.
// ----------------------------------------------------------------------------
module dma_tx_ring_buffer_unit
    import dtrb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], read_index[20:8]
    input  logic                 s_tlast,
    input  logic [1:0]           s_tuser,  // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0], launch_valid[1], launch_start[14:2], launch_length[28:15],
    // read_data[36:29], free_space[50:37]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wen,
    input  logic                 cfg_wdata
);

    dtrb_cmd_t    cmd;
    dtrb_result_t result;

    dtrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dtrb_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_mode           (s_tuser),
        .in_data_byte      (s_tdata[7:0]),
        .in_end_of_message (s_tlast),
        .in_read_index     (s_tdata[8 +: IDX_W]),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .result            (result)
    );

    assign m_tdata = {{(M_TDATA_W - $bits(dtrb_result_t)){1'b0}}, result};

endmodule

FILE: tb/sv/tb_dma_tx_ring_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_tx_ring_buffer_unit
// Self-checking bench for the transmit ring buffer. A shadow of the buffer
// pointers, free space and link state predicts the status beat of every
// accepted command beat. Directed cases run first: pushes while stopped,
// launches, chained runs, done while not busy and link toggles. Random
// message traffic with completions, reads of stored entries and noise
// follows. The sender idles in bursts and the receiver stalls on changing
// patterns.
// ----------------------------------------------------------------------------
module tb_dma_tx_ring_buffer_unit;
    import dtrb_pkg::*;

    localparam int RES_W        = $bits(dtrb_result_t);
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        mode_t            op;
        logic [7:0]       data_v;
        logic             eom;
        logic [IDX_W-1:0] rd_idx;
    } ring_cmd_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wen   = 1'b0;
    logic                 cfg_wdata = 1'b0;

    ring_cmd_t    pending_cmds[$];
    ring_cmd_t    cur_cmd = '0;
    ring_cmd_t    next_cmd;
    dtrb_result_t due_status[$];
    dtrb_result_t got_status;
    dtrb_result_t want_status;

    int burst_left  = 0;
    int gap_left    = 0;
    int stall_mode  = 0;
    int stall_timer = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int cmds_queued = 0;

    // write position as seen when queuing, and top of the stored entries
    int q_head = 0;
    int wr_top = 0;

    // shadow of the buffer
    logic [7:0] shadow_mem [BUFFER_BYTES];
    int         head_ptr;
    int         tail_ptr;
    int         run_end;
    int         free_cnt;
    run_state_t link_st;

    dma_tx_ring_buffer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void open_run(output int run_start, output int run_len);
        int stop_at;
        stop_at = head_ptr;
        if (stop_at < tail_ptr || (stop_at == tail_ptr && free_cnt == 0))
            stop_at = BUFFER_BYTES;
        run_start = tail_ptr;
        run_len   = stop_at - tail_ptr;
        run_end   = stop_at;
        link_st   = RUN_BUSY;
    endfunction

    function automatic void predict_status(ring_cmd_t c);
        dtrb_result_t st;
        int           run_start;
        int           run_len;
        int           sent;
        st        = '0;
        run_start = 0;
        run_len   = 0;
        case (c.op)
            MODE_PUSH: begin
                if (free_cnt > 0) begin
                    shadow_mem[head_ptr] = c.data_v;
                    head_ptr = (head_ptr + 1) % BUFFER_BYTES;
                    free_cnt--;
                    st.accepted = 1'b1;
                end
                if (c.eom && link_st == RUN_IDLE) begin
                    open_run(run_start, run_len);
                    st.launch_valid = 1'b1;
                end
            end
            MODE_DONE: begin
                if (link_st == RUN_BUSY) begin
                    sent     = (run_end >= tail_ptr) ? run_end - tail_ptr : 0;
                    free_cnt = (free_cnt + sent > BUFFER_BYTES) ? BUFFER_BYTES
                                                                : free_cnt + sent;
                    if (run_end >= BUFFER_BYTES)
                        run_end = 0;
                    tail_ptr = run_end;
                    if (head_ptr == tail_ptr && free_cnt != 0) begin
                        link_st = RUN_IDLE;
                    end else begin
                        open_run(run_start, run_len);
                        st.launch_valid = 1'b1;
                    end
                end
            end
            MODE_READ: begin
                st.read_data = shadow_mem[c.rd_idx];
            end
            default: ;
        endcase
        st.launch_start  = IDX_W'(run_start);
        st.launch_length = LEN_W'(run_len);
        st.free_space    = LEN_W'(free_cnt);
        due_status.push_back(st);
    endfunction

    function automatic void queue_cmd(mode_t op, logic [7:0] data_v, logic eom,
                                      logic [IDX_W-1:0] idx);
        ring_cmd_t c;
        c.op     = op;
        c.data_v = data_v;
        c.eom    = eom;
        c.rd_idx = idx;
        pending_cmds.push_back(c);
        cmds_queued++;
        if (op == MODE_PUSH && q_head < BUFFER_BYTES) begin
            q_head++;
            if (q_head > wr_top)
                wr_top = q_head;
        end
    endfunction

    function automatic void queue_any(mode_t op);
        queue_cmd(op, 8'($urandom), 1'($urandom), IDX_W'($urandom));
    endfunction

    // read one of the entries stored so far
    function automatic void queue_read();
        queue_cmd(MODE_READ, 8'($urandom), 1'($urandom),
                  IDX_W'($urandom_range(0, wr_top - 1)));
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || due_status.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_link(logic on);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= on;
        if (on) begin
            if (link_st == RUN_STOPPED)
                link_st = RUN_IDLE;
        end else begin
            link_st  = RUN_STOPPED;
            head_ptr = 0;
            tail_ptr = 0;
            run_end  = 0;
            free_cnt = BUFFER_BYTES;
            q_head   = 0;
        end
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // command beats, bursts with gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_status(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    cur_cmd  <= next_cmd;
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({next_cmd.rd_idx, next_cmd.data_v});
                    s_tuser  <= next_cmd.op;
                    s_tlast  <= next_cmd.eom;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_mode  <= 0;
            stall_timer <= 0;
        end else begin
            if (stall_timer == 0) begin
                stall_mode  <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(20, 120);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // status beat check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_status = dtrb_result_t'(m_tdata[RES_W-1:0]);
            if (due_status.size() == 0) begin
                report_mismatch("status beat with none due", 0, 0);
            end else begin
                want_status = due_status.pop_front();
                if (got_status.accepted !== want_status.accepted)
                    report_mismatch("accepted", 32'(got_status.accepted),
                                    32'(want_status.accepted));
                if (got_status.launch_valid !== want_status.launch_valid)
                    report_mismatch("launch_valid", 32'(got_status.launch_valid),
                                    32'(want_status.launch_valid));
                if (got_status.launch_start !== want_status.launch_start)
                    report_mismatch("launch_start", 32'(got_status.launch_start),
                                    32'(want_status.launch_start));
                if (got_status.launch_length !== want_status.launch_length)
                    report_mismatch("launch_length", 32'(got_status.launch_length),
                                    32'(want_status.launch_length));
                if (got_status.read_data !== want_status.read_data)
                    report_mismatch("read_data", 32'(got_status.read_data),
                                    32'(want_status.read_data));
                if (got_status.free_space !== want_status.free_space)
                    report_mismatch("free_space", 32'(got_status.free_space),
                                    32'(want_status.free_space));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int i;
        int len;
        int sel;
        int rand_base;

        head_ptr = 0;
        tail_ptr = 0;
        run_end  = 0;
        free_cnt = BUFFER_BYTES;
        link_st  = RUN_STOPPED;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // link stopped: bytes stored, nothing launched
        queue_cmd(MODE_PUSH, 8'h00, 1'b1, IDX_W'($urandom));
        queue_cmd(MODE_PUSH, 8'hff, 1'b0, IDX_W'($urandom));
        queue_cmd(MODE_PUSH, 8'ha5, 1'b1, IDX_W'($urandom));
        queue_any(MODE_DONE);
        queue_any(MODE_NOP);
        queue_cmd(MODE_READ, 8'($urandom), 1'b0, IDX_W'(0));
        queue_cmd(MODE_READ, 8'($urandom), 1'b1, IDX_W'(1));
        queue_cmd(MODE_READ, 8'($urandom), 1'b0, IDX_W'(2));
        wait_drained();
        write_link(1'b1);

        // launch, end byte while busy, chained run, done while idle
        queue_cmd(MODE_PUSH, 8'h5a, 1'b1, IDX_W'($urandom));
        queue_cmd(MODE_PUSH, 8'h11, 1'b1, IDX_W'($urandom));
        queue_any(MODE_DONE);
        queue_any(MODE_DONE);
        queue_any(MODE_DONE);
        queue_cmd(MODE_READ, 8'($urandom), 1'b0, IDX_W'(4));
        wait_drained();
        write_link(1'b1);
        write_link(1'b0);
        write_link(1'b1);

        // random messages with completions, reads and noise
        rand_base = cmds_queued;
        while (cmds_queued - rand_base < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                len = ($urandom_range(0, 49) == 0) ? $urandom_range(40, 300)
                                                   : $urandom_range(1, 24);
                for (i = 0; i < len; i++)
                    queue_cmd(MODE_PUSH, 8'($urandom), i == len - 1, IDX_W'($urandom));
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    queue_any(MODE_DONE);
                if (sel < 2)
                    queue_any(MODE_DONE);
            end else if (sel < 70) begin
                queue_any(MODE_DONE);
            end else if (sel < 85) begin
                queue_read();
            end else if (sel < 92) begin
                queue_any(MODE_NOP);
            end else begin
                queue_any(MODE_PUSH);
            end
            if ($urandom_range(0, 59) == 0) begin
                wait_drained();
                if ($urandom_range(0, 2) == 0) begin
                    write_link(1'b0);
                    queue_any(MODE_PUSH);
                    queue_any(MODE_DONE);
                    queue_cmd(MODE_PUSH, 8'($urandom), 1'b1, IDX_W'($urandom));
                    wait_drained();
                end
                write_link(1'b1);
            end
            while (pending_cmds.size() > 16)
                @(negedge aclk);
        end

        wait_drained();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
